// ===== rtl/core/aes128_pkg.sv =====
// package for the aes-128 block encrypt core: types, s-box and round helpers
package aes128_pkg;

   localparam int NumRoundsDef = 10;
   localparam int BlockBytes   = 16;
   localparam int ColLast      = 3;

   typedef logic [127:0] block_type;
   typedef logic [7:0]   byte_type;

   typedef struct packed {
      logic      load;
      logic      last;
      logic      mix;
      block_type key;
   } round_ctl_type;

   function automatic byte_type sbox(input byte_type x);
      byte_type s;
      case (x)
         8'h00: s = 8'h63; 8'h01: s = 8'h7c; 8'h02: s = 8'h77; 8'h03: s = 8'h7b;
         8'h04: s = 8'hf2; 8'h05: s = 8'h6b; 8'h06: s = 8'h6f; 8'h07: s = 8'hc5;
         8'h08: s = 8'h30; 8'h09: s = 8'h01; 8'h0a: s = 8'h67; 8'h0b: s = 8'h2b;
         8'h0c: s = 8'hfe; 8'h0d: s = 8'hd7; 8'h0e: s = 8'hab; 8'h0f: s = 8'h76;
         8'h10: s = 8'hca; 8'h11: s = 8'h82; 8'h12: s = 8'hc9; 8'h13: s = 8'h7d;
         8'h14: s = 8'hfa; 8'h15: s = 8'h59; 8'h16: s = 8'h47; 8'h17: s = 8'hf0;
         8'h18: s = 8'had; 8'h19: s = 8'hd4; 8'h1a: s = 8'ha2; 8'h1b: s = 8'haf;
         8'h1c: s = 8'h9c; 8'h1d: s = 8'ha4; 8'h1e: s = 8'h72; 8'h1f: s = 8'hc0;
         8'h20: s = 8'hb7; 8'h21: s = 8'hfd; 8'h22: s = 8'h93; 8'h23: s = 8'h26;
         8'h24: s = 8'h36; 8'h25: s = 8'h3f; 8'h26: s = 8'hf7; 8'h27: s = 8'hcc;
         8'h28: s = 8'h34; 8'h29: s = 8'ha5; 8'h2a: s = 8'he5; 8'h2b: s = 8'hf1;
         8'h2c: s = 8'h71; 8'h2d: s = 8'hd8; 8'h2e: s = 8'h31; 8'h2f: s = 8'h15;
         8'h30: s = 8'h04; 8'h31: s = 8'hc7; 8'h32: s = 8'h23; 8'h33: s = 8'hc3;
         8'h34: s = 8'h18; 8'h35: s = 8'h96; 8'h36: s = 8'h05; 8'h37: s = 8'h9a;
         8'h38: s = 8'h07; 8'h39: s = 8'h12; 8'h3a: s = 8'h80; 8'h3b: s = 8'he2;
         8'h3c: s = 8'heb; 8'h3d: s = 8'h27; 8'h3e: s = 8'hb2; 8'h3f: s = 8'h75;
         8'h40: s = 8'h09; 8'h41: s = 8'h83; 8'h42: s = 8'h2c; 8'h43: s = 8'h1a;
         8'h44: s = 8'h1b; 8'h45: s = 8'h6e; 8'h46: s = 8'h5a; 8'h47: s = 8'ha0;
         8'h48: s = 8'h52; 8'h49: s = 8'h3b; 8'h4a: s = 8'hd6; 8'h4b: s = 8'hb3;
         8'h4c: s = 8'h29; 8'h4d: s = 8'he3; 8'h4e: s = 8'h2f; 8'h4f: s = 8'h84;
         8'h50: s = 8'h53; 8'h51: s = 8'hd1; 8'h52: s = 8'h00; 8'h53: s = 8'hed;
         8'h54: s = 8'h20; 8'h55: s = 8'hfc; 8'h56: s = 8'hb1; 8'h57: s = 8'h5b;
         8'h58: s = 8'h6a; 8'h59: s = 8'hcb; 8'h5a: s = 8'hbe; 8'h5b: s = 8'h39;
         8'h5c: s = 8'h4a; 8'h5d: s = 8'h4c; 8'h5e: s = 8'h58; 8'h5f: s = 8'hcf;
         8'h60: s = 8'hd0; 8'h61: s = 8'hef; 8'h62: s = 8'haa; 8'h63: s = 8'hfb;
         8'h64: s = 8'h43; 8'h65: s = 8'h4d; 8'h66: s = 8'h33; 8'h67: s = 8'h85;
         8'h68: s = 8'h45; 8'h69: s = 8'hf9; 8'h6a: s = 8'h02; 8'h6b: s = 8'h7f;
         8'h6c: s = 8'h50; 8'h6d: s = 8'h3c; 8'h6e: s = 8'h9f; 8'h6f: s = 8'ha8;
         8'h70: s = 8'h51; 8'h71: s = 8'ha3; 8'h72: s = 8'h40; 8'h73: s = 8'h8f;
         8'h74: s = 8'h92; 8'h75: s = 8'h9d; 8'h76: s = 8'h38; 8'h77: s = 8'hf5;
         8'h78: s = 8'hbc; 8'h79: s = 8'hb6; 8'h7a: s = 8'hda; 8'h7b: s = 8'h21;
         8'h7c: s = 8'h10; 8'h7d: s = 8'hff; 8'h7e: s = 8'hf3; 8'h7f: s = 8'hd2;
         8'h80: s = 8'hcd; 8'h81: s = 8'h0c; 8'h82: s = 8'h13; 8'h83: s = 8'hec;
         8'h84: s = 8'h5f; 8'h85: s = 8'h97; 8'h86: s = 8'h44; 8'h87: s = 8'h17;
         8'h88: s = 8'hc4; 8'h89: s = 8'ha7; 8'h8a: s = 8'h7e; 8'h8b: s = 8'h3d;
         8'h8c: s = 8'h64; 8'h8d: s = 8'h5d; 8'h8e: s = 8'h19; 8'h8f: s = 8'h73;
         8'h90: s = 8'h60; 8'h91: s = 8'h81; 8'h92: s = 8'h4f; 8'h93: s = 8'hdc;
         8'h94: s = 8'h22; 8'h95: s = 8'h2a; 8'h96: s = 8'h90; 8'h97: s = 8'h88;
         8'h98: s = 8'h46; 8'h99: s = 8'hee; 8'h9a: s = 8'hb8; 8'h9b: s = 8'h14;
         8'h9c: s = 8'hde; 8'h9d: s = 8'h5e; 8'h9e: s = 8'h0b; 8'h9f: s = 8'hdb;
         8'ha0: s = 8'he0; 8'ha1: s = 8'h32; 8'ha2: s = 8'h3a; 8'ha3: s = 8'h0a;
         8'ha4: s = 8'h49; 8'ha5: s = 8'h06; 8'ha6: s = 8'h24; 8'ha7: s = 8'h5c;
         8'ha8: s = 8'hc2; 8'ha9: s = 8'hd3; 8'haa: s = 8'hac; 8'hab: s = 8'h62;
         8'hac: s = 8'h91; 8'had: s = 8'h95; 8'hae: s = 8'he4; 8'haf: s = 8'h79;
         8'hb0: s = 8'he7; 8'hb1: s = 8'hc8; 8'hb2: s = 8'h37; 8'hb3: s = 8'h6d;
         8'hb4: s = 8'h8d; 8'hb5: s = 8'hd5; 8'hb6: s = 8'h4e; 8'hb7: s = 8'ha9;
         8'hb8: s = 8'h6c; 8'hb9: s = 8'h56; 8'hba: s = 8'hf4; 8'hbb: s = 8'hea;
         8'hbc: s = 8'h65; 8'hbd: s = 8'h7a; 8'hbe: s = 8'hae; 8'hbf: s = 8'h08;
         8'hc0: s = 8'hba; 8'hc1: s = 8'h78; 8'hc2: s = 8'h25; 8'hc3: s = 8'h2e;
         8'hc4: s = 8'h1c; 8'hc5: s = 8'ha6; 8'hc6: s = 8'hb4; 8'hc7: s = 8'hc6;
         8'hc8: s = 8'he8; 8'hc9: s = 8'hdd; 8'hca: s = 8'h74; 8'hcb: s = 8'h1f;
         8'hcc: s = 8'h4b; 8'hcd: s = 8'hbd; 8'hce: s = 8'h8b; 8'hcf: s = 8'h8a;
         8'hd0: s = 8'h70; 8'hd1: s = 8'h3e; 8'hd2: s = 8'hb5; 8'hd3: s = 8'h66;
         8'hd4: s = 8'h48; 8'hd5: s = 8'h03; 8'hd6: s = 8'hf6; 8'hd7: s = 8'h0e;
         8'hd8: s = 8'h61; 8'hd9: s = 8'h35; 8'hda: s = 8'h57; 8'hdb: s = 8'hb9;
         8'hdc: s = 8'h86; 8'hdd: s = 8'hc1; 8'hde: s = 8'h1d; 8'hdf: s = 8'h9e;
         8'he0: s = 8'he1; 8'he1: s = 8'hf8; 8'he2: s = 8'h98; 8'he3: s = 8'h11;
         8'he4: s = 8'h69; 8'he5: s = 8'hd9; 8'he6: s = 8'h8e; 8'he7: s = 8'h94;
         8'he8: s = 8'h9b; 8'he9: s = 8'h1e; 8'hea: s = 8'h87; 8'heb: s = 8'he9;
         8'hec: s = 8'hce; 8'hed: s = 8'h55; 8'hee: s = 8'h28; 8'hef: s = 8'hdf;
         8'hf0: s = 8'h8c; 8'hf1: s = 8'ha1; 8'hf2: s = 8'h89; 8'hf3: s = 8'h0d;
         8'hf4: s = 8'hbf; 8'hf5: s = 8'he6; 8'hf6: s = 8'h42; 8'hf7: s = 8'h68;
         8'hf8: s = 8'h41; 8'hf9: s = 8'h99; 8'hfa: s = 8'h2d; 8'hfb: s = 8'h0f;
         8'hfc: s = 8'hb0; 8'hfd: s = 8'h54; 8'hfe: s = 8'hbb; 8'hff: s = 8'h16;
         default: s = 8'h00;
      endcase
      return s;
   endfunction

   function automatic byte_type gf_double(input byte_type x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of the block sits in bits 127-8i down to 120-8i
   function automatic byte_type get_byte(input block_type b, input int i);
      return b[127 - 8 * i -: 8];
   endfunction

endpackage

// ===== rtl/core/aes128_ram.sv =====
// generic simple dual-port ram with registered read
module aes128_ram #(
   parameter int Width = 64,
   parameter int Depth = 22
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/core/aes128_column_cell.sv =====
// one column cell: holds a state column, does sub, mix and key add on bytes shifted in from its neighbors
module aes128_column_cell (
   input  logic                           clock,
   input  aes128_pkg::round_ctl_type      ctl,
   input  logic [31:0]                    load_col,
   input  logic [3:0][7:0]                shift_in,
   output logic [31:0]                    col_out
);
   import aes128_pkg::*;

   logic [31:0] col_ff, col_in;
   byte_type    s0, s1, s2, s3, all, m0, m1, m2, m3;
   logic [31:0] key_col, mixed;

   assign key_col = ctl.key[127:96];

   always_comb begin
      // shift_in row r already comes from the neighbor column (c + r)
      s0 = sbox(shift_in[0]);
      s1 = sbox(shift_in[1]);
      s2 = sbox(shift_in[2]);
      s3 = sbox(shift_in[3]);
      all = s0 ^ s1 ^ s2 ^ s3;
      m0 = gf_double(s0 ^ s1) ^ s0 ^ all;
      m1 = gf_double(s1 ^ s2) ^ s1 ^ all;
      m2 = gf_double(s2 ^ s3) ^ s2 ^ all;
      m3 = gf_double(s3 ^ s0) ^ s3 ^ all;
      mixed = ctl.mix ? {m0, m1, m2, m3} : {s0, s1, s2, s3};
      if (ctl.load) begin
         col_in = load_col ^ key_col;
      end else if (ctl.last) begin
         col_in = col_ff;
      end else begin
         col_in = mixed ^ key_col;
      end
   end

   always_ff @(posedge clock) begin
      col_ff <= col_in;
   end

   assign col_out = col_ff;
endmodule

// ===== rtl/core/aes128_block_encrypt_core.sv =====
// top level of the aes-128 block encrypt core
//  channel | dir | ports                                   | beat
//  req     | in  | req_type, req_key_round, req_data_hi/lo | req_valid & !req_stall
//  rsp     | out | rsp_cipher_hi, rsp_cipher_lo            | rsp_valid & !rsp_stall
// a load beat writes both key halves in its own cycle and never stalls the next beat
// an encrypt beat runs 11 rounds, one per cycle, in the row of four column cells;
// the key rams are read with the next round index, so each round's key is registered by the time the round runs
// the done state then moves the cipher to the output register, which raises rsp_valid;
// the next beat is taken once the core is back in idle
// reset clears control only; the key rams hold garbage until loaded
// req_stall is high while a block is in the cells; a waiting result holds the
// cells only when the next cipher is done before the output register is free
module aes128_block_encrypt_core #(
   parameter int NUM_ROUNDS = aes128_pkg::NumRoundsDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [3:0]  req_key_round,
   input  logic [63:0] req_data_hi,
   input  logic [63:0] req_data_lo,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_cipher_hi,
   output logic [63:0] rsp_cipher_lo
);
   import aes128_pkg::*;

   localparam int KeyRounds = NUM_ROUNDS + 1;
   localparam int AddrW     = $clog2(KeyRounds);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_RUN   = 3'b010,
      ST_DONE  = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [AddrW-1:0] rnd_ff, rnd_in;
   block_type        pt_ff, pt_in;
   block_type        res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             accept, wr_en, fire;
   logic [AddrW-1:0] wr_addr;
   logic [63:0]      key_hi, key_lo;
   round_ctl_type    ctl [4];
   logic [31:0]      col [4];

   assign req_stall = state_ff != ST_IDLE;
   assign accept    = req_valid && !req_stall;

   // loads above the last round are dropped
   assign wr_en   = accept && !req_type && (req_key_round <= 4'(NUM_ROUNDS));
   assign wr_addr = AddrW'(req_key_round);

   // read address runs one round ahead of the cells
   aes128_ram #(.Width(64), .Depth(KeyRounds)) u_keys_hi (
      .clock, .wr_en, .wr_addr, .wr_data(req_data_hi), .rd_addr(rnd_in), .rd_data(key_hi)
   );

   aes128_ram #(.Width(64), .Depth(KeyRounds)) u_keys_lo (
      .clock, .wr_en, .wr_addr, .wr_data(req_data_lo), .rd_addr(rnd_in), .rd_data(key_lo)
   );

   always_comb begin
      state_in     = state_ff;
      rnd_in       = rnd_ff;
      pt_in        = pt_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_type) begin
               state_in = ST_RUN;
               rnd_in   = '0;
               pt_in    = {req_data_hi, req_data_lo};
            end
         end
         ST_RUN: begin
            if (rnd_ff == AddrW'(NUM_ROUNDS)) begin
               state_in = ST_DONE;
            end else begin
               rnd_in = rnd_ff + AddrW'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in     = ST_IDLE;
               res_in       = {col[0], col[1], col[2], col[3]};
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign fire = state_ff == ST_RUN;

   for (genvar c = 0; c < 4; c++) begin : g_cell
      logic [3:0][7:0] sh;
      always_comb begin
         for (int r = 0; r < 4; r++) begin
            sh[r] = col[(c + r) % 4][31 - 8 * r -: 8];
         end
         ctl[c].load = fire && (rnd_ff == '0);
         ctl[c].last = !fire;
         ctl[c].mix  = rnd_ff != AddrW'(NUM_ROUNDS);
         ctl[c].key  = {key_hi, key_lo} << (32 * c);
      end
      aes128_column_cell u_cell (
         .clock, .ctl(ctl[c]), .load_col(pt_ff[127 - 32 * c -: 32]),
         .shift_in(sh), .col_out(col[c])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rnd_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rnd_ff       <= rnd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pt_ff  <= pt_in;
      res_ff <= res_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_cipher_hi = res_ff[127:64];
   assign rsp_cipher_lo = res_ff[63:0];

   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall) else $error("busy without stall");
   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_cipher_hi) && $stable(rsp_cipher_lo)))
      else $error("result dropped or changed while stalled");
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   a_round_range: assert property (@(posedge clock) disable iff (reset)
      fire |-> (rnd_ff <= AddrW'(NUM_ROUNDS))) else $error("round index out of range");
endmodule
